FILE: rtl/core/padt_pkg.sv
// Shared types, constants, delay table and divide helper of the phase-angle dimmer timer.
package padt_pkg;

  // Duty scale: full duty is 2^DUTY_W - 1 (the divide helper relies on this form)
  localparam int DUTY_W    = 12;
  localparam int DUTY_FULL = (1 << DUTY_W) - 1;

  // Linear-power delay table
  localparam int LUT_ENTRIES = 200;
  localparam int LUT_IDX_W   = $clog2(LUT_ENTRIES);

  localparam logic [15:0] DELAY_OFF = 16'hffff;

  // Input commands (carried in tuser)
  localparam logic [1:0] CMD_SET_DUTY   = 2'd0;
  localparam logic [1:0] CMD_ZERO_CROSS = 2'd1;
  localparam logic [1:0] CMD_TICK       = 2'd2;
  localparam logic [1:0] CMD_NONE       = 2'd3;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SEMI_PERIOD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LUT_ENABLE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POWER_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_POWER   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_POWER   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_GATE    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DIMMER_EN   = 3'd6;

  // Configuration register file contents
  typedef struct packed {
    logic [15:0]       semi_period_us;
    logic              lut_enable;
    logic [DUTY_W-1:0] power_limit;
    logic [DUTY_W-1:0] min_power;
    logic [DUTY_W-1:0] max_power;
    logic [9:0]        min_gate_delay_us;
    logic              dimmer_enable;
  } cfg_t;

  // Controller to datapath step strobes
  typedef struct packed {
    logic load;     // capture request
    logic mul;      // clamp and duty*span
    logic remap;    // mapped duty
    logic scale;    // table position and linear product
    logic index;    // table fraction and linear quotient
    logic interp;   // table slope times fraction
    logic fin;      // interpolated value times semi-period
    logic commit;   // update state and load result register
  } ctrl_cmd_t;

  // Datapath status back to the controller
  typedef struct packed {
    logic out_free;
  } dp_stat_t;

  // Delays in units of 1/65536 semi-period, decreasing
  localparam logic [15:0] DELAY_TABLE [LUT_ENTRIES] = '{
    16'hffff, 16'he877, 16'he240, 16'hddd9, 16'hda51, 16'hd74f, 16'hd4aa, 16'hd248,
    16'hd01a, 16'hce16, 16'hcc34, 16'hca6e, 16'hc8c0, 16'hc728, 16'hc5a1, 16'hc42b,
    16'hc2c3, 16'hc168, 16'hc019, 16'hbed3, 16'hbd98, 16'hbc65, 16'hbb3b, 16'hba17,
    16'hb8fb, 16'hb7e5, 16'hb6d5, 16'hb5ca, 16'hb4c5, 16'hb3c4, 16'hb2c8, 16'hb1d1,
    16'hb0dd, 16'hafed, 16'haf01, 16'hae18, 16'had33, 16'hac51, 16'hab71, 16'haa95,
    16'ha9bb, 16'ha8e3, 16'ha80e, 16'ha73b, 16'ha66b, 16'ha59c, 16'ha4d0, 16'ha406,
    16'ha33d, 16'ha276, 16'ha1b1, 16'ha0ed, 16'ha02b, 16'h9f6b, 16'h9eac, 16'h9dee,
    16'h9d32, 16'h9c76, 16'h9bbc, 16'h9b04, 16'h9a4c, 16'h9996, 16'h98e0, 16'h982b,
    16'h9778, 16'h96c5, 16'h9613, 16'h9563, 16'h94b2, 16'h9403, 16'h9354, 16'h92a6,
    16'h91f9, 16'h914c, 16'h90a0, 16'h8ff5, 16'h8f4a, 16'h8ea0, 16'h8df6, 16'h8d4d,
    16'h8ca4, 16'h8bfb, 16'h8b53, 16'h8aab, 16'h8a04, 16'h895d, 16'h88b6, 16'h8810,
    16'h876a, 16'h86c4, 16'h861e, 16'h8579, 16'h84d3, 16'h842e, 16'h8389, 16'h82e4,
    16'h823f, 16'h819b, 16'h80f6, 16'h8051, 16'h7fad, 16'h7f08, 16'h7e63, 16'h7dbf,
    16'h7d1a, 16'h7c75, 16'h7bd0, 16'h7b2b, 16'h7a85, 16'h79e0, 16'h793a, 16'h7894,
    16'h77ee, 16'h7748, 16'h76a1, 16'h75fa, 16'h7553, 16'h74ab, 16'h7403, 16'h735a,
    16'h72b1, 16'h7208, 16'h715e, 16'h70b4, 16'h7009, 16'h6f5e, 16'h6eb2, 16'h6e05,
    16'h6d58, 16'h6caa, 16'h6bfb, 16'h6b4c, 16'h6a9b, 16'h69eb, 16'h6939, 16'h6886,
    16'h67d3, 16'h671e, 16'h6668, 16'h65b2, 16'h64fa, 16'h6442, 16'h6388, 16'h62cc,
    16'h6210, 16'h6152, 16'h6093, 16'h5fd3, 16'h5f11, 16'h5e4d, 16'h5d88, 16'h5cc1,
    16'h5bf8, 16'h5b2e, 16'h5a62, 16'h5993, 16'h58c3, 16'h57f0, 16'h571b, 16'h5643,
    16'h5569, 16'h548d, 16'h53ad, 16'h52cb, 16'h51e6, 16'h50fd, 16'h5011, 16'h4f21,
    16'h4e2d, 16'h4d36, 16'h4c3a, 16'h4b39, 16'h4a34, 16'h4929, 16'h4819, 16'h4703,
    16'h45e7, 16'h44c3, 16'h4399, 16'h4266, 16'h412b, 16'h3fe5, 16'h3e96, 16'h3d3b,
    16'h3bd3, 16'h3a5d, 16'h38d6, 16'h373e, 16'h3590, 16'h33ca, 16'h31e8, 16'h2fe4,
    16'h2db6, 16'h2b54, 16'h28af, 16'h25ad, 16'h2225, 16'h1dbe, 16'h1787, 16'h0000
  };

  // floor(p / DUTY_FULL) for p < 2^28 and a quotient below 2^16.
  // p = 4096*hi + lo = 4095*hi + (hi + lo); fold twice, then one correction.
  function automatic logic [15:0] div_dfull(input logic [27:0] p);
    logic [15:0] hi;
    logic [16:0] t;
    logic [4:0]  hi2;
    logic [12:0] t2;
    logic [16:0] q;
    hi  = p[27:DUTY_W];
    t   = {1'b0, hi} + {5'b0, p[DUTY_W-1:0]};
    hi2 = t[16:DUTY_W];
    t2  = {8'b0, hi2} + {1'b0, t[DUTY_W-1:0]};
    q   = {1'b0, hi} + {12'b0, hi2} + {16'b0, (t2 >= 13'(DUTY_FULL))};
    return q[15:0];
  endfunction

endpackage

FILE: rtl/core/padt_cfg.sv
// Configuration register file of the phase-angle dimmer timer.
module padt_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [padt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_wdata,
  output padt_pkg::cfg_t                 cfg
);

  padt_pkg::cfg_t cfg_r, cfg_nxt;

  // Decode a write into the addressed field
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        padt_pkg::REG_SEMI_PERIOD: cfg_nxt.semi_period_us    = cfg_wdata;
        padt_pkg::REG_LUT_ENABLE:  cfg_nxt.lut_enable        = cfg_wdata[0];
        padt_pkg::REG_POWER_LIMIT: cfg_nxt.power_limit       = cfg_wdata[padt_pkg::DUTY_W-1:0];
        padt_pkg::REG_MIN_POWER:   cfg_nxt.min_power         = cfg_wdata[padt_pkg::DUTY_W-1:0];
        padt_pkg::REG_MAX_POWER:   cfg_nxt.max_power         = cfg_wdata[padt_pkg::DUTY_W-1:0];
        padt_pkg::REG_MIN_GATE:    cfg_nxt.min_gate_delay_us = cfg_wdata[9:0];
        padt_pkg::REG_DIMMER_EN:   cfg_nxt.dimmer_enable     = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.semi_period_us    <= 16'd10000;
      cfg_r.lut_enable        <= 1'b1;
      cfg_r.power_limit       <= padt_pkg::DUTY_W'(padt_pkg::DUTY_FULL);
      cfg_r.min_power         <= '0;
      cfg_r.max_power         <= padt_pkg::DUTY_W'(padt_pkg::DUTY_FULL);
      cfg_r.min_gate_delay_us <= 10'd90;
      cfg_r.dimmer_enable     <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/core/padt_ctrl.sv
// Sequencing state machine of the phase-angle dimmer timer.
module padt_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic [1:0]            in_cmd,
  output logic                  in_tready,
  input  padt_pkg::dp_stat_t    stat,
  output padt_pkg::ctrl_cmd_t   cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MAP    = 3'd1;
  localparam logic [2:0] ST_REMAP  = 3'd2;
  localparam logic [2:0] ST_SCALE  = 3'd3;
  localparam logic [2:0] ST_INDEX  = 3'd4;
  localparam logic [2:0] ST_INTERP = 3'd5;
  localparam logic [2:0] ST_FIN    = 3'd6;
  localparam logic [2:0] ST_COMMIT = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       accept;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  // Next state and step strobes
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.load  = 1'b1;
          state_nxt = (in_cmd == padt_pkg::CMD_SET_DUTY) ? ST_MAP : ST_COMMIT;
        end
      end
      ST_MAP: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_REMAP;
      end
      ST_REMAP: begin
        cmd.remap = 1'b1;
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = ST_INDEX;
      end
      ST_INDEX: begin
        cmd.index = 1'b1;
        state_nxt = ST_INTERP;
      end
      ST_INTERP: begin
        cmd.interp = 1'b1;
        state_nxt  = ST_FIN;
      end
      ST_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        // hold here while the previous result is still waiting
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/core/padt_dp.sv
// Datapath of the phase-angle dimmer timer: delay arithmetic, timer state, result register.
module padt_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  padt_pkg::cfg_t      cfg,
  input  padt_pkg::ctrl_cmd_t cmd,
  output padt_pkg::dp_stat_t  stat,
  input  logic [1:0]          in_cmd,
  input  logic [31:0]         in_data,
  input  logic                out_tready,
  output logic                out_tvalid,
  output logic [23:0]         out_data
);

  localparam int DW = padt_pkg::DUTY_W;
  localparam int IW = padt_pkg::LUT_IDX_W;

  // Captured request
  logic [1:0]  cmd_r;
  logic [DW-1:0] duty_r;
  logic [15:0] lead_r;

  // Set-duty pipeline registers
  logic [2*DW-1:0] prod_r;
  logic            dzero_r;
  logic [DW-1:0]   m_r;
  logic [15:0]     u_r;
  logic [27:0]     lin_r;
  logic [15:0]     lin_q_r;
  logic [IW+15:0]  s_r;
  logic [31:0]     ip_r;
  logic [15:0]     ta_r;
  logic [31:0]     tbl_r;

  // Timer state
  logic [15:0] fd_r, fd_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic [15:0] alarm_r, alarm_nxt;
  logic        pend_r, pend_nxt;
  logic        gate_r, gate_nxt;

  // Result register
  logic        ovalid_r;
  logic [23:0] odata_r;

  // Arithmetic intermediates
  logic [DW-1:0]  d_clamp, span, quo, m_calc;
  logic [15:0]    quo_full;
  logic           up;
  logic [IW-1:0]  idx, idx_raw;
  logic [15:0]    ta, tb, v_val, set_delay, a_val, tick_inc;
  logic           lead_pos;

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r  <= in_cmd;
      duty_r <= in_data[DW-1:0];
      lead_r <= in_data[27:12];
    end
  end

  // Clamp and remap
  always_comb begin
    d_clamp  = (duty_r < cfg.power_limit) ? duty_r : cfg.power_limit;
    up       = (cfg.max_power >= cfg.min_power);
    span     = up ? (cfg.max_power - cfg.min_power) : (cfg.min_power - cfg.max_power);
    quo_full = padt_pkg::div_dfull({4'b0, prod_r});
    quo      = quo_full[DW-1:0];
    m_calc   = up ? (cfg.min_power + quo) : (cfg.min_power - quo);
  end

  // Table lookup with saturated index
  always_comb begin
    idx_raw = s_r[IW+15:16];
    idx     = (idx_raw > IW'(padt_pkg::LUT_ENTRIES - 2)) ?
              IW'(padt_pkg::LUT_ENTRIES - 2) : idx_raw;
    ta      = padt_pkg::DELAY_TABLE[idx];
    tb      = padt_pkg::DELAY_TABLE[idx + IW'(1)];
    v_val   = ta_r - ip_r[31:16];
  end

  // Set-duty pipeline steps
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r  <= {{DW{1'b0}}, d_clamp} * {{DW{1'b0}}, span};
      dzero_r <= (d_clamp == '0);
    end
    if (cmd.remap) begin
      m_r <= dzero_r ? '0 : m_calc;
    end
    if (cmd.scale) begin
      // position in the table: m * 65535 / DUTY_FULL
      u_r   <= padt_pkg::div_dfull({m_r, 16'b0} - {16'b0, m_r});
      lin_r <= {16'b0, (DW'(padt_pkg::DUTY_FULL) - m_r)} * {12'b0, cfg.semi_period_us};
    end
    if (cmd.index) begin
      s_r     <= (IW+16)'({{IW{1'b0}}, u_r} * (IW+16)'(padt_pkg::LUT_ENTRIES - 1))
                 + (IW+16)'((padt_pkg::LUT_ENTRIES - 1) >> 1);
      lin_q_r <= padt_pkg::div_dfull(lin_r);
    end
    if (cmd.interp) begin
      ip_r <= {16'b0, (ta - tb)} * {16'b0, s_r[15:0]};
      ta_r <= ta;
    end
    if (cmd.fin) begin
      tbl_r <= {16'b0, v_val} * {16'b0, cfg.semi_period_us};
    end
  end

  // Firing delay selection
  always_comb begin
    if (m_r == '0) begin
      set_delay = padt_pkg::DELAY_OFF;
    end else if (m_r == DW'(padt_pkg::DUTY_FULL)) begin
      set_delay = '0;
    end else if (cfg.lut_enable && (cfg.semi_period_us != '0)) begin
      set_delay = tbl_r[31:16];
    end else begin
      set_delay = lin_q_r;
    end
  end

  // Timer state update on commit
  always_comb begin
    fd_nxt    = fd_r;
    tick_nxt  = tick_r;
    alarm_nxt = alarm_r;
    pend_nxt  = pend_r;
    gate_nxt  = gate_r;
    tick_inc  = tick_r + 16'd1;
    lead_pos  = !lead_r[15] && (lead_r != '0);
    a_val     = (fd_r < {6'b0, cfg.min_gate_delay_us}) ? {6'b0, cfg.min_gate_delay_us} : fd_r;
    if (lead_pos && (a_val > lead_r)) begin
      a_val = a_val - lead_r;
    end
    unique case (cmd_r)
      padt_pkg::CMD_SET_DUTY: begin
        fd_nxt = set_delay;
      end
      padt_pkg::CMD_ZERO_CROSS: begin
        if (cfg.dimmer_enable) begin
          if (fd_r == '0) begin
            pend_nxt = 1'b0;
            gate_nxt = 1'b1;
          end else if (fd_r == padt_pkg::DELAY_OFF) begin
            pend_nxt = 1'b0;
            gate_nxt = 1'b0;
          end else begin
            gate_nxt  = 1'b0;
            tick_nxt  = '0;
            alarm_nxt = a_val;
            pend_nxt  = 1'b1;
          end
        end
      end
      padt_pkg::CMD_TICK: begin
        tick_nxt = tick_inc;
        if (pend_r && (tick_inc == alarm_r)) begin
          gate_nxt = 1'b1;
          pend_nxt = 1'b0;
        end
      end
      padt_pkg::CMD_NONE: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fd_r    <= padt_pkg::DELAY_OFF;
      tick_r  <= '0;
      alarm_r <= '0;
      pend_r  <= 1'b0;
      gate_r  <= 1'b0;
    end else if (cmd.commit) begin
      fd_r    <= fd_nxt;
      tick_r  <= tick_nxt;
      alarm_r <= alarm_nxt;
      pend_r  <= pend_nxt;
      gate_r  <= gate_nxt;
    end
  end

  // Result register: loaded on commit, freed when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (cmd.commit) begin
      ovalid_r <= 1'b1;
    end else if (out_tready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      odata_r <= {6'b0, pend_nxt, fd_nxt, gate_nxt};
    end
  end

  assign stat.out_free = !ovalid_r || out_tready;
  assign out_tvalid    = ovalid_r;
  assign out_data      = odata_r;

endmodule

FILE: rtl/core/phase_angle_dimmer_timer_top.sv
// Top level of the phase-angle dimmer timer.
//
// Input stream: one request per handshake; in_tuser carries the command
// (set duty, zero crossing, microsecond tick), in_tdata the duty and the
// signed lead time. Each request produces exactly one result on the output
// stream: gate level, current firing delay and alarm-pending flag, all as
// they stand after the request.
// Every request other than set duty goes from accept straight to the commit
// step; a set-duty request first passes through the six-step sequence
// clamp/multiply, remap, scale, index, interpolate, final multiply.
// One request at a time: the next is taken only once the last is committed.
// A finished result sits in an output register; the next request is taken
// while it waits. If the receiver stalls, the block holds its next result
// in the commit step, leaving timer state untouched until it can be sent.
// Reset (synchronous, active low) sets configuration and timer state to defaults,
// delay off, gate low, no alarm pending, no result valid; the block is ready at once.
// Configuration writes are taken at any time and should be made while idle.
module phase_angle_dimmer_timer_top (
  input  logic                           clk,
  input  logic                           rst_n,
  // input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [31:0]                    in_tdata,   // duty[11:0], lead_time_us[27:12]
  input  logic [1:0]                     in_tuser,   // command[1:0]
  // output stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [23:0]                    out_tdata,  // gate[0], firing_delay_us[16:1],
                                                     // alarm_armed[17]
  // configuration
  input  logic                           cfg_we,
  input  logic [padt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_wdata
);

  padt_pkg::cfg_t      cfg;
  padt_pkg::ctrl_cmd_t cmd;
  padt_pkg::dp_stat_t  stat;

  padt_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  padt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_cmd    (in_tuser),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  padt_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .cmd        (cmd),
    .stat       (stat),
    .in_cmd     (in_tuser),
    .in_data    (in_tdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_data   (out_tdata)
  );

endmodule

FILE: tb/dimmer_gate_checker.sv
`timescale 1ns / 100ps
// Checker for the dimmer timer: watches streams and register port, predicts and compares.
module dimmer_gate_checker
  import padt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [31:0]          in_tdata,
  input  logic [1:0]           in_tuser,
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [23:0]          out_tdata,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_wdata,
  output int                   fail_count,
  output int                   results_seen,
  output int                   pending,
  output int                   timer_fires
);

  localparam longint unsigned FULL_DUTY = 4095;
  localparam int TABLE_PTS = 200;
  localparam int MAX_REPORTS = 10;

  // Linear-power firing delays, in 1/65536 of a half-cycle
  localparam logic [15:0] LIN_POWER_DELAY [TABLE_PTS] = '{
    16'hffff, 16'he877, 16'he240, 16'hddd9, 16'hda51, 16'hd74f, 16'hd4aa, 16'hd248,
    16'hd01a, 16'hce16, 16'hcc34, 16'hca6e, 16'hc8c0, 16'hc728, 16'hc5a1, 16'hc42b,
    16'hc2c3, 16'hc168, 16'hc019, 16'hbed3, 16'hbd98, 16'hbc65, 16'hbb3b, 16'hba17,
    16'hb8fb, 16'hb7e5, 16'hb6d5, 16'hb5ca, 16'hb4c5, 16'hb3c4, 16'hb2c8, 16'hb1d1,
    16'hb0dd, 16'hafed, 16'haf01, 16'hae18, 16'had33, 16'hac51, 16'hab71, 16'haa95,
    16'ha9bb, 16'ha8e3, 16'ha80e, 16'ha73b, 16'ha66b, 16'ha59c, 16'ha4d0, 16'ha406,
    16'ha33d, 16'ha276, 16'ha1b1, 16'ha0ed, 16'ha02b, 16'h9f6b, 16'h9eac, 16'h9dee,
    16'h9d32, 16'h9c76, 16'h9bbc, 16'h9b04, 16'h9a4c, 16'h9996, 16'h98e0, 16'h982b,
    16'h9778, 16'h96c5, 16'h9613, 16'h9563, 16'h94b2, 16'h9403, 16'h9354, 16'h92a6,
    16'h91f9, 16'h914c, 16'h90a0, 16'h8ff5, 16'h8f4a, 16'h8ea0, 16'h8df6, 16'h8d4d,
    16'h8ca4, 16'h8bfb, 16'h8b53, 16'h8aab, 16'h8a04, 16'h895d, 16'h88b6, 16'h8810,
    16'h876a, 16'h86c4, 16'h861e, 16'h8579, 16'h84d3, 16'h842e, 16'h8389, 16'h82e4,
    16'h823f, 16'h819b, 16'h80f6, 16'h8051, 16'h7fad, 16'h7f08, 16'h7e63, 16'h7dbf,
    16'h7d1a, 16'h7c75, 16'h7bd0, 16'h7b2b, 16'h7a85, 16'h79e0, 16'h793a, 16'h7894,
    16'h77ee, 16'h7748, 16'h76a1, 16'h75fa, 16'h7553, 16'h74ab, 16'h7403, 16'h735a,
    16'h72b1, 16'h7208, 16'h715e, 16'h70b4, 16'h7009, 16'h6f5e, 16'h6eb2, 16'h6e05,
    16'h6d58, 16'h6caa, 16'h6bfb, 16'h6b4c, 16'h6a9b, 16'h69eb, 16'h6939, 16'h6886,
    16'h67d3, 16'h671e, 16'h6668, 16'h65b2, 16'h64fa, 16'h6442, 16'h6388, 16'h62cc,
    16'h6210, 16'h6152, 16'h6093, 16'h5fd3, 16'h5f11, 16'h5e4d, 16'h5d88, 16'h5cc1,
    16'h5bf8, 16'h5b2e, 16'h5a62, 16'h5993, 16'h58c3, 16'h57f0, 16'h571b, 16'h5643,
    16'h5569, 16'h548d, 16'h53ad, 16'h52cb, 16'h51e6, 16'h50fd, 16'h5011, 16'h4f21,
    16'h4e2d, 16'h4d36, 16'h4c3a, 16'h4b39, 16'h4a34, 16'h4929, 16'h4819, 16'h4703,
    16'h45e7, 16'h44c3, 16'h4399, 16'h4266, 16'h412b, 16'h3fe5, 16'h3e96, 16'h3d3b,
    16'h3bd3, 16'h3a5d, 16'h38d6, 16'h373e, 16'h3590, 16'h33ca, 16'h31e8, 16'h2fe4,
    16'h2db6, 16'h2b54, 16'h28af, 16'h25ad, 16'h2225, 16'h1dbe, 16'h1787, 16'h0000
  };

  typedef struct packed {
    logic        armed;
    logic [15:0] delay;
    logic        gate;
  } gate_report_t;

  // Register copy
  logic [15:0] half_cycle;
  logic        lut_on;
  logic [11:0] power_limit;
  logic [11:0] min_power;
  logic [11:0] max_power;
  logic [9:0]  min_gate;
  logic        dimmer_on;

  // Timer state copy
  logic [15:0] delay_now;
  logic [15:0] tick_count;
  logic [15:0] alarm_at;
  logic        alarm_pending;
  logic        gate_level;

  gate_report_t gate_report_q[$];
  int mismatch_cnt;
  int checked_cnt;
  int fire_cnt;

  // Interpolated table lookup scaled by the half-cycle
  function automatic logic [15:0] table_delay_us(input longint unsigned m,
                                                 input longint unsigned semi);
    longint unsigned u, s, idx, a, b, v;
    u = (m * 64'hFFFF) / FULL_DUTY;
    s = u * (TABLE_PTS - 1) + ((TABLE_PTS - 1) >> 1);
    idx = s >> 16;
    if (idx > TABLE_PTS - 2) idx = TABLE_PTS - 2;
    a = LIN_POWER_DELAY[idx];
    b = LIN_POWER_DELAY[idx + 1];
    v = a - (((a - b) * (s & 64'hFFFF)) >> 16);
    return 16'((v * semi) >> 16);
  endfunction

  // Clamp, remap and convert a requested duty into a firing delay
  function automatic logic [15:0] delay_for_duty(input logic [11:0] duty);
    longint unsigned d, lo, hi, m, semi;
    d = (duty < power_limit) ? duty : power_limit;
    lo = min_power;
    hi = max_power;
    semi = half_cycle;
    if (d == 0) m = 0;
    else if (hi >= lo) m = lo + (d * (hi - lo)) / FULL_DUTY;
    else m = lo - (d * (lo - hi)) / FULL_DUTY;
    if (m == 0) return 16'hFFFF;
    if (m >= FULL_DUTY) return 16'h0000;
    if (lut_on && semi != 0) return table_delay_us(m, semi);
    return 16'(((FULL_DUTY - m) * semi) / FULL_DUTY);
  endfunction

  // Zero crossing (dimmer enabled): drive full on/off at once, or drop the gate and arm the alarm
  function automatic void zero_crossing(input logic [15:0] lead_raw);
    logic signed [15:0] lead_s;
    int lead;
    int arm;
    lead_s = lead_raw;
    lead = lead_s;
    if (!dimmer_on) return;
    if (delay_now == 16'h0000) begin
      alarm_pending = 1'b0;
      gate_level = 1'b1;
      return;
    end
    if (delay_now == 16'hFFFF) begin
      alarm_pending = 1'b0;
      gate_level = 1'b0;
      return;
    end
    gate_level = 1'b0;
    arm = (delay_now < min_gate) ? int'(min_gate) : int'(delay_now);
    if (lead > 0 && arm > lead) arm = arm - lead;
    tick_count = 16'h0000;
    alarm_at = 16'(arm);
    alarm_pending = 1'b1;
  endfunction

  // Microsecond tick: fire the gate when the counter meets the alarm
  function automatic void usec_tick();
    tick_count = tick_count + 16'd1;
    if (alarm_pending && tick_count == alarm_at) begin
      gate_level = 1'b1;
      alarm_pending = 1'b0;
      fire_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    gate_report_t want;
    gate_report_t got;
    if (!rst_n) begin
      half_cycle = 16'd10000;
      lut_on = 1'b1;
      power_limit = 12'd4095;
      min_power = 12'd0;
      max_power = 12'd4095;
      min_gate = 10'd90;
      dimmer_on = 1'b1;
      delay_now = 16'hFFFF;
      tick_count = '0;
      alarm_at = '0;
      alarm_pending = 1'b0;
      gate_level = 1'b0;
      gate_report_q.delete();
      mismatch_cnt = 0;
      checked_cnt = 0;
      fire_cnt = 0;
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_SEMI_PERIOD: half_cycle = cfg_wdata;
          REG_LUT_ENABLE:  lut_on = cfg_wdata[0];
          REG_POWER_LIMIT: power_limit = cfg_wdata[11:0];
          REG_MIN_POWER:   min_power = cfg_wdata[11:0];
          REG_MAX_POWER:   max_power = cfg_wdata[11:0];
          REG_MIN_GATE:    min_gate = cfg_wdata[9:0];
          REG_DIMMER_EN:   dimmer_on = cfg_wdata[0];
          default: ;
        endcase
      end

      // result side
      if (out_tvalid && out_tready) begin
        got.gate = out_tdata[0];
        got.delay = out_tdata[16:1];
        got.armed = out_tdata[17];
        checked_cnt++;
        if (gate_report_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("ERROR: result %0d with no request outstanding (tdata %h)",
                     checked_cnt, out_tdata);
        end else begin
          want = gate_report_q.pop_front();
          if (got.gate !== want.gate || got.delay !== want.delay ||
              got.armed !== want.armed) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS)
              $display("ERROR: result %0d exp/got gate %b/%b delay %0d/%0d armed %b/%b",
                       checked_cnt, want.gate, got.gate, want.delay, got.delay,
                       want.armed, got.armed);
          end
        end
      end

      // request side
      if (in_tvalid && in_tready) begin
        case (in_tuser)
          CMD_SET_DUTY:   delay_now = delay_for_duty(in_tdata[11:0]);
          CMD_ZERO_CROSS: zero_crossing(in_tdata[27:12]);
          CMD_TICK:       usec_tick();
          default: ;
        endcase
        want.gate = gate_level;
        want.delay = delay_now;
        want.armed = alarm_pending;
        gate_report_q.push_back(want);
      end
    end
    fail_count <= mismatch_cnt;
    results_seen <= checked_cnt;
    pending <= gate_report_q.size();
    timer_fires <= fire_cnt;
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// Testbench top for the dimmer timer: clock, reset, stimulus, receiver stalls and verdict.
module tb;
  import padt_pkg::*;

  localparam int ITEM_TARGET  = 1750;
  localparam int NUM_SETTINGS = 16;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 400;
  localparam int TICK_CAP     = 300;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [31:0]          in_tdata;   // duty[11:0], lead_time_us[27:12]
  logic [1:0]           in_tuser;   // command[1:0]
  logic                 out_tvalid;
  logic                 out_tready;
  logic [23:0]          out_tdata;  // gate[0], firing_delay_us[16:1], alarm_armed[17]
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_wdata;

  int fail_count;
  int results_seen;
  int pending;
  int timer_fires;

  int idle_pct = 22;
  bit hold_req = 1'b0;
  int cycle_cnt = 0;
  int sent_cnt = 0;
  int cmd_cnt[4] = '{0, 0, 0, 0};
  logic [15:0] cur_semi = 16'd10000;
  logic [9:0]  cur_min_gate = 10'd90;

  phase_angle_dimmer_timer_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  dimmer_gate_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .results_seen (results_seen),
    .pending      (pending),
    .timer_fires  (timer_fires)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_tready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Offer one request, with random gaps ahead of it; returns at the accepting edge
  task automatic send_request(input logic [1:0] cmd, input logic [11:0] duty,
                              input logic [15:0] lead);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {4'b0, lead, duty};
    do @(posedge clk); while (!in_tready);
    sent_cnt++;
    cmd_cnt[cmd]++;
  endtask

  // Stop offering and wait until every result is back
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (results_seen != sent_cnt) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic write_settings(input logic [15:0] semi, input logic lut,
                                input logic [11:0] lim, input logic [11:0] lo,
                                input logic [11:0] hi, input logic [9:0] gate_min,
                                input logic en);
    write_reg(REG_SEMI_PERIOD, semi);
    write_reg(REG_LUT_ENABLE, {15'b0, lut});
    write_reg(REG_POWER_LIMIT, {4'b0, lim});
    write_reg(REG_MIN_POWER, {4'b0, lo});
    write_reg(REG_MAX_POWER, {4'b0, hi});
    write_reg(REG_MIN_GATE, {6'b0, gate_min});
    write_reg(REG_DIMMER_EN, {15'b0, en});
    cfg_we <= 1'b0;
    cur_semi = semi;
    cur_min_gate = gate_min;
  endtask

  // Fixed corner settings first, random ones after
  task automatic apply_setting(input int k);
    case (k)
      0:  write_settings(16'd200,   1'b1, 12'd4095, 12'd0,    12'd4095, 10'd10,   1'b1);
      1:  write_settings(16'd150,   1'b0, 12'd3000, 12'd500,  12'd3500, 10'd0,    1'b1);
      2:  write_settings(16'd0,     1'b1, 12'd4095, 12'd0,    12'd4095, 10'd5,    1'b1);
      3:  write_settings(16'hFFFF,  1'b1, 12'd4095, 12'd0,    12'd4095, 10'd1023, 1'b1);
      4:  write_settings(16'hFFFF,  1'b0, 12'd2048, 12'd0,    12'd4095, 10'd1023, 1'b1);
      5:  write_settings(16'd250,   1'b1, 12'd4095, 12'd4000, 12'd100,  10'd20,   1'b1);
      6:  write_settings(16'd180,   1'b0, 12'd4095, 12'd4095, 12'd0,    10'd0,    1'b1);
      7:  write_settings(16'd120,   1'b1, 12'd0,    12'd0,    12'd4095, 10'd30,   1'b1);
      8:  write_settings(16'd100,   1'b1, 12'd4095, 12'd4095, 12'd4095, 10'd0,    1'b0);
      9:  write_settings(16'd220,   1'b0, 12'd4095, 12'd0,    12'd0,    10'd15,   1'b1);
      default: begin
        write_settings(($urandom_range(99) < 75) ? 16'($urandom_range(300)) : 16'($urandom()),
                       1'($urandom()),
                       ($urandom_range(99) < 25) ? 12'd4095 : 12'($urandom()),
                       ($urandom_range(99) < 30) ? 12'd0 : 12'($urandom()),
                       ($urandom_range(99) < 30) ? 12'd4095 : 12'($urandom()),
                       ($urandom_range(99) < 70) ? 10'($urandom_range(60)) : 10'($urandom()),
                       ($urandom_range(99) < 85));
      end
    endcase
  endtask

  function automatic logic [11:0] pick_duty();
    case ($urandom_range(9))
      0: return 12'd0;
      1: return 12'd4095;
      2: return 12'd1;
      3: return 12'd4094;
      default: return 12'($urandom());
    endcase
  endfunction

  function automatic logic [15:0] pick_lead();
    case ($urandom_range(7))
      0, 1, 2: return 16'($urandom_range(40, 1));
      3: return 16'd0;
      4: return 16'h8000 | 16'($urandom());
      5: return 16'($urandom_range(32767, 1024));
      default: return 16'($urandom());
    endcase
  endfunction

  // One mains half-cycle: maybe a new duty, a zero crossing, then a run of ticks
  // (the run is cut short where the remaining request budget ends)
  task automatic run_half_cycle(input int budget);
    int span;
    int n_ticks;
    if ($urandom_range(99) < 40) send_request(CMD_SET_DUTY, pick_duty(), 16'($urandom()));
    send_request(CMD_ZERO_CROSS, 12'($urandom()), pick_lead());
    span = int'(cur_semi) + int'(cur_min_gate) + 8;
    if (span > TICK_CAP) span = TICK_CAP;
    n_ticks = $urandom_range(span, span / 3);
    if (n_ticks > budget) n_ticks = budget;
    repeat (n_ticks) begin
      // occasional stray request in the middle of the half-cycle
      if ($urandom_range(99) < 3)
        send_request(2'($urandom()), 12'($urandom()), 16'($urandom()));
      else
        send_request(CMD_TICK, 12'($urandom()), 16'($urandom()));
    end
  endtask

  initial begin
    int quota;
    int start_cnt;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = CMD_NONE;
    cfg_we = 1'b0;
    cfg_index = REG_SEMI_PERIOD;
    cfg_wdata = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests at reset settings
    send_request(CMD_ZERO_CROSS, 12'd0,    16'd0);       // off at reset
    send_request(CMD_SET_DUTY,   12'd4095, 16'hFFFF);    // full on
    send_request(CMD_ZERO_CROSS, 12'hFFF,  16'h7FFF);    // gate high at once
    send_request(CMD_TICK,       12'd0,    16'd0);
    send_request(CMD_SET_DUTY,   12'd0,    16'h8000);    // off
    send_request(CMD_ZERO_CROSS, 12'd0,    16'h8000);    // gate low at once
    send_request(CMD_SET_DUTY,   12'd1,    16'd0);       // top end of the table
    send_request(CMD_SET_DUTY,   12'd4094, 16'd0);       // bottom end of the table
    send_request(CMD_SET_DUTY,   12'd2048, 16'd0);
    send_request(CMD_ZERO_CROSS, 12'd0,    16'd0);       // arm without lead
    send_request(CMD_TICK,       12'd0,    16'd0);
    send_request(CMD_TICK,       12'hFFF,  16'hFFFF);
    send_request(CMD_ZERO_CROSS, 12'd0,    16'd100);     // lead shortens the alarm
    send_request(CMD_ZERO_CROSS, 12'd0,    16'h7FFF);    // lead longer than delay
    send_request(CMD_ZERO_CROSS, 12'd0,    16'h8000);    // negative lead
    send_request(CMD_NONE,       12'hFFF,  16'hFFFF);    // unused code
    send_request(CMD_NONE,       12'd0,    16'd0);
    send_request(CMD_TICK,       12'd0,    16'd0);
    send_request(CMD_SET_DUTY,   12'hAAA,  16'h5555);
    send_request(CMD_SET_DUTY,   12'h555,  16'hAAAA);

    // Random half-cycles across register settings
    quota = ITEM_TARGET / NUM_SETTINGS;
    for (int k = 0; k < NUM_SETTINGS; k++) begin
      wait_idle();
      apply_setting(k);
      idle_pct = (k == 1 || k == 2) ? 0 : 22;
      if (k == 0 || k == 11) hold_req = 1'b1;
      start_cnt = sent_cnt;
      while (sent_cnt - start_cnt < quota) run_half_cycle(quota - (sent_cnt - start_cnt));
    end

    wait_idle();
    repeat (10) @(posedge clk);
    $display("Covered %0d requests (%0d set-duty, %0d zero-cross, %0d tick, %0d unused)",
             sent_cnt, cmd_cnt[CMD_SET_DUTY], cmd_cnt[CMD_ZERO_CROSS], cmd_cnt[CMD_TICK],
             cmd_cnt[CMD_NONE]);
    $display("over %0d register settings; %0d results checked, %0d timer firings, %0d bad",
             NUM_SETTINGS + 1, results_seen, timer_fires, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
